### rtl/cave_pkg.sv
`default_nettype none

package cave_pkg;

	// Largest row the datapath is built for.
	localparam int CAVE_MAX_ROW_CELLS = 64;

	// Fixed field widths.
	localparam int ROW_W   = 64;
	localparam int LIMIT_W = 4;
	localparam int WIDTH_W = 7;
	localparam int INDEX_W = 3;
	localparam int CFG_W   = 7;

	// Register reset values.
	localparam logic [LIMIT_W-1:0] SURVIVE_LOW_RST  = 4'd4;
	localparam logic [LIMIT_W-1:0] SURVIVE_HIGH_RST = 4'd8;
	localparam logic [LIMIT_W-1:0] BIRTH_LOW_RST    = 4'd5;
	localparam logic [WIDTH_W-1:0] ACTIVE_WIDTH_RST = 7'd64;

	// Configuration register indexes.
	typedef enum logic [INDEX_W-1:0] {
		REG_SURVIVE_LOW  = 3'd0,
		REG_SURVIVE_HIGH = 3'd1,
		REG_BIRTH_LOW    = 3'd2,
		REG_ACTIVE_WIDTH = 3'd3,
		REG_BORDER_WALL  = 3'd4
	} cave_reg_t;

	// One input row.
	typedef struct packed {
		logic [ROW_W-1:0] row_cells;
		logic             last_row;
	} cave_in_t;

	// One result row.
	typedef struct packed {
		logic [ROW_W-1:0] next_cells;
		logic             frame_end;
		logic             run_end;
	} cave_out_t;

	// Rule settings seen by the evolve logic; width is already clamped.
	typedef struct packed {
		logic [LIMIT_W-1:0] survive_low;
		logic [LIMIT_W-1:0] survive_high;
		logic [LIMIT_W-1:0] birth_low;
		logic [WIDTH_W-1:0] width;
		logic               border_wall;
	} cave_rule_t;

endpackage

`default_nettype wire

### rtl/cave_automaton_row_step.sv
`default_nettype none

// Streams a grid one row per transfer, top row first, and returns the next
// generation of the cave automaton one row per transfer. A result row needs
// the row below it, so each row comes out after the following row has been
// taken; the bottom row (last_row set) releases both the held row and its
// own result, in that order. The block takes one row per clock cycle while
// out_stall is low; only a bottom row that follows a held row holds off the
// next row until its first result is issued, because its two results share
// the single output register. Configuration may be written only while no
// row is in flight; a new grid starts after each bottom row.
module cave_automaton_row_step
	import cave_pkg::*;
#(
	parameter int MAX_ROW_CELLS = CAVE_MAX_ROW_CELLS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [INDEX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  cave_in_t           in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output cave_out_t          out_data
);

	localparam logic [WIDTH_W-1:0] MAX_CELLS = WIDTH_W'(MAX_ROW_CELLS);

	// Configuration registers.
	logic [LIMIT_W-1:0] survive_low_q;
	logic [LIMIT_W-1:0] survive_high_q;
	logic [LIMIT_W-1:0] birth_low_q;
	logic [WIDTH_W-1:0] active_width_q;
	logic               border_wall_q;

	// Grid state between rows.
	logic [ROW_W-1:0] above_q;
	logic [ROW_W-1:0] held_q;
	logic             row_held_q;
	logic             first_q;

	// Work stage: up to two results pending for the accepted row.
	logic [ROW_W-1:0] row_s1;
	logic [ROW_W-1:0] held_s1;
	logic [ROW_W-1:0] above_s1;
	logic             first_s1;
	logic             had_held_s1;
	logic             a_pend_s1;
	logic             b_pend_s1;

	logic             out_valid_q;
	cave_out_t        out_q;

	cave_rule_t       rule;
	logic [WIDTH_W-1:0] eff_width;
	logic [ROW_W-1:0] width_mask;
	logic [ROW_W-1:0] row_m;
	logic             in_xfer;
	logic             out_free;
	logic             busy;
	logic             issue;
	logic             s1_free;
	logic [ROW_W-1:0] job_up;
	logic [ROW_W-1:0] job_mid;
	logic [ROW_W-1:0] job_down;
	logic             job_top;
	logic             job_bottom;
	logic             job_run_end;
	logic [ROW_W-1:0] job_result;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			survive_low_q  <= SURVIVE_LOW_RST;
			survive_high_q <= SURVIVE_HIGH_RST;
			birth_low_q    <= BIRTH_LOW_RST;
			active_width_q <= ACTIVE_WIDTH_RST;
			border_wall_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SURVIVE_LOW:  survive_low_q  <= cfg_data[LIMIT_W-1:0];
				REG_SURVIVE_HIGH: survive_high_q <= cfg_data[LIMIT_W-1:0];
				REG_BIRTH_LOW:    birth_low_q    <= cfg_data[LIMIT_W-1:0];
				REG_ACTIVE_WIDTH: active_width_q <= cfg_data[WIDTH_W-1:0];
				REG_BORDER_WALL:  border_wall_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamp the active width to the range the row supports.
	always_comb begin
		if (active_width_q == '0) begin
			eff_width = 7'd1;
		end else if (active_width_q > MAX_CELLS) begin
			eff_width = MAX_CELLS;
		end else begin
			eff_width = active_width_q;
		end
	end

	for (genvar i = 0; i < ROW_W; i++) begin : g_mask
		assign width_mask[i] = (WIDTH_W'(i) < eff_width);
	end

	assign rule = '{survive_low: survive_low_q, survive_high: survive_high_q,
		birth_low: birth_low_q, width: eff_width, border_wall: border_wall_q};

	// Handshake control.
	assign row_m    = in_data.row_cells & width_mask;
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign busy     = a_pend_s1 || b_pend_s1;
	assign issue    = busy && out_free;
	assign s1_free  = !busy || (issue && !(a_pend_s1 && b_pend_s1));
	assign in_stall = !s1_free;

	// Row history: the held row waits for its lower neighbor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q    <= '0;
			held_q     <= '0;
			row_held_q <= 1'b0;
			first_q    <= 1'b1;
		end else if (in_xfer) begin
			if (in_data.last_row) begin
				above_q    <= '0;
				held_q     <= '0;
				row_held_q <= 1'b0;
				first_q    <= 1'b1;
			end else begin
				above_q    <= row_held_q ? held_q : '0;
				held_q     <= row_m;
				row_held_q <= 1'b1;
				if (row_held_q) begin
					first_q <= 1'b0;
				end
			end
		end
	end

	// Work stage pending flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_pend_s1 <= 1'b0;
			b_pend_s1 <= 1'b0;
		end else if (in_xfer) begin
			a_pend_s1 <= row_held_q;
			b_pend_s1 <= in_data.last_row;
		end else if (issue) begin
			if (a_pend_s1) begin
				a_pend_s1 <= 1'b0;
			end else begin
				b_pend_s1 <= 1'b0;
			end
		end
	end

	// Work stage rows.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			row_s1      <= row_m;
			held_s1     <= held_q;
			above_s1    <= above_q;
			first_s1    <= first_q;
			had_held_s1 <= row_held_q;
		end
	end

	// The held row goes first; the bottom row follows on its own.
	always_comb begin
		if (a_pend_s1) begin
			job_up      = above_s1;
			job_mid     = held_s1;
			job_down    = row_s1;
			job_top     = first_s1;
			job_bottom  = 1'b0;
			job_run_end = !b_pend_s1;
		end else begin
			job_up      = had_held_s1 ? held_s1 : '0;
			job_mid     = row_s1;
			job_down    = '0;
			job_top     = !had_held_s1;
			job_bottom  = 1'b1;
			job_run_end = 1'b1;
		end
	end

	cave_row_evolve u_evolve (
		.rule   (rule),
		.up     (job_up),
		.mid    (job_mid),
		.down   (job_down),
		.top    (job_top),
		.bottom (job_bottom),
		.result (job_result)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			out_q.next_cells <= job_result;
			out_q.frame_end  <= job_bottom;
			out_q.run_end    <= job_run_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

### rtl/cave_row_evolve.sv
`default_nettype none

module cave_row_evolve
	import cave_pkg::*;
(
	input  cave_rule_t       rule,
	input  logic [ROW_W-1:0] up,
	input  logic [ROW_W-1:0] mid,
	input  logic [ROW_W-1:0] down,
	input  logic             top,
	input  logic             bottom,
	output logic [ROW_W-1:0] result
);

	logic [ROW_W-1:0] mask;
	logic [ROW_W-1:0] up_m;
	logic [ROW_W-1:0] mid_m;
	logic [ROW_W-1:0] down_m;
	logic [ROW_W+1:0] up_p;
	logic [ROW_W+1:0] mid_p;
	logic [ROW_W+1:0] down_p;

	// Rows padded with a clear cell on each side so every window is in range.
	assign up_m   = up & mask;
	assign mid_m  = mid & mask;
	assign down_m = down & mask;
	assign up_p   = {1'b0, up_m, 1'b0};
	assign mid_p  = {1'b0, mid_m, 1'b0};
	assign down_p = {1'b0, down_m, 1'b0};

	for (genvar x = 0; x < ROW_W; x++) begin : g_cell
		localparam logic [WIDTH_W-1:0] XPOS = WIDTH_W'(x);
		logic [3:0] count;
		logic       wall;

		assign mask[x] = (XPOS < rule.width);

		// Wall count over the 3x3 window, the cell itself included.
		assign count = 4'(up_p[x])   + 4'(up_p[x+1])   + 4'(up_p[x+2])
			+ 4'(mid_p[x])  + 4'(mid_p[x+1])  + 4'(mid_p[x+2])
			+ 4'(down_p[x]) + 4'(down_p[x+1]) + 4'(down_p[x+2]);

		// Survive or birth rule, then the optional wall frame.
		always_comb begin
			if (mid_m[x]) begin
				wall = (count >= rule.survive_low) && (count <= rule.survive_high);
			end else begin
				wall = (count >= rule.birth_low);
			end
			if (rule.border_wall) begin
				if (top || bottom || (x == 0) || (XPOS == rule.width - 7'd1)) begin
					wall = 1'b1;
				end
			end
		end

		assign result[x] = wall & mask[x];
	end

endmodule

`default_nettype wire

### rtl/cave_checker.sv
`default_nettype none

module cave_checker
	import cave_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_stall,
	input  logic      out_valid,
	input  logic      out_stall,
	input  cave_out_t out_data
);

	// A stalled result holds until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// The bottom row of a grid is always the last result of its row.
	a_frame_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_end |-> out_data.run_end)
		else $error("frame end without run end");

	// A result that is not the last of its row is followed at once by the next.
	a_pair_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.run_end |=> out_valid)
		else $error("second result of a row did not follow");

	// A non-final result comes only together with a grid bottom row after it.
	a_pair_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.run_end |=> out_data.frame_end)
		else $error("paired result is not the bottom row");

	// The input is refused only while a result is still pending.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |-> out_valid || $past(in_valid && !in_stall))
		else $error("input stalled with nothing in flight");

endmodule

bind cave_automaton_row_step cave_checker u_cave_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire
